>>> hdl/can_bit_timing_calculator_macros.svh
// Assertion macros shared by the CAN bit-timing calculator RTL.
`ifndef CAN_BIT_TIMING_CALCULATOR_MACROS_SVH
`define CAN_BIT_TIMING_CALCULATOR_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication checked at every rising clock edge outside reset.
`define CBTC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("CAN bit-timing calculator assertion failed");
// Next-cycle implication checked at every rising clock edge outside reset.
`define CBTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("CAN bit-timing calculator assertion failed");
`else
`define CBTC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define CBTC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hdl/cbtc_pkg.sv
// Package with types, codes and constants of the CAN bit-timing calculator.
`timescale 1ns / 1ps
package cbtc_pkg;

   localparam int RATE_W   = 10;
   localparam int OSC_W    = 6;
   localparam int NUM_W    = 15;
   localparam int STATUS_W = 2;
   localparam int CNF_W    = 8;

   localparam int NUM_SCALE = 500;

   localparam int DEF_MAX_QUANTA      = 25;
   localparam int DEF_PRESCALER_TRIES = 8;

   localparam logic [OSC_W-1:0]  OSC_RESET    = 6'd16;
   localparam logic [RATE_W-1:0] SPECIAL_RATE = 10'd83;
   localparam logic [CNF_W-1:0]  SPECIAL_CNF1 = 8'h03;
   localparam logic [CNF_W-1:0]  SPECIAL_CNF2 = 8'hBE;
   localparam logic [CNF_W-1:0]  SPECIAL_CNF3 = 8'h07;
   localparam logic [CNF_W-1:0]  CNF2_LENGTH_MODE = 8'h80;

   // floor(4*q/5) computed as (4*q*205) >> 10, exact for 4*q below 1024.
   localparam int SPT_RECIP = 205;
   localparam int SPT_SHIFT = 10;

   localparam int SEG_MAX     = 8;
   localparam int SEG_MIN     = 1;
   localparam int PHASE2_MIN  = 2;

   localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_PRESCALER = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_SEGMENTS = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_SEGMENT,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

>>> hdl/cbtc_div.sv
// Restoring unsigned divider producing one quotient bit per cycle.
`timescale 1ns / 1ps
module cbtc_div
   import cbtc_pkg::*;
#(
   parameter int DIVIDEND_W = NUM_W,
   parameter int DIVISOR_W  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output div_status_type        status,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic [DIVISOR_W-1:0]  remainder
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   always_comb begin
      trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff  = trial - {1'b0, dsr_ff};
      fits  = (trial >= {1'b0, dsr_ff});
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CNT_W'(DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;
   assign remainder   = rem_ff;

endmodule

>>> hdl/can_bit_timing_calculator.sv
// Top level of the CAN bit-timing calculator: sequencer, segment logic and ports.
// Sequence: a rate of 83 or 0 goes from the accepting state straight to the result; any
// other rate runs one divider pass per prescaler try, until a fit leads to the segment
// state or the last try fails; the result state loads the response when the output is free.
// Throughput: one transaction at a time, ready again in the cycle after the response is
// loaded; each try starts the divider in DIV_START and waits for it in DIV_WAIT.
// Reset: synchronous, active high; osc_mhz returns to 16 and the block is idle.
`timescale 1ns / 1ps
module can_bit_timing_calculator
   import cbtc_pkg::*;
#(
   parameter int MAX_QUANTA      = DEF_MAX_QUANTA,
   parameter int PRESCALER_TRIES = DEF_PRESCALER_TRIES
) (
   input  logic        clock,
   input  logic        reset,
   // Configuration write channel for osc_mhz.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [5:0]  csr_wdata,     // osc_mhz[5:0]
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,     // bit_rate_kbps[9:0], zero padding [15:10]
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,     // cnf1[7:0], cnf2[15:8], cnf3[23:16]
   output logic [1:0]  rsp_tuser      // status[1:0]
);

`include "can_bit_timing_calculator_macros.svh"

   // The search walks prescaler values in order. The denominator (p+1)*rate is kept
   // as a running sum so that each try only adds the rate once; the division itself
   // goes through one shared bit-serial divider.
   localparam int BRP_W = (PRESCALER_TRIES > 1) ? $clog2(PRESCALER_TRIES) : 1;
   localparam int DEN_W = RATE_W + BRP_W;
   localparam int Q_W   = $clog2(MAX_QUANTA + 1);
   localparam int X_W   = Q_W + 2;
   localparam int P_W   = X_W + 8;
   localparam int SW    = Q_W + 3;
   localparam int RES_W = 3 * CNF_W;

   state_type                state_ff, state_in;
   logic [OSC_W-1:0]         osc_ff, osc_in;
   logic [RATE_W-1:0]        rate_ff, rate_in;
   logic [NUM_W-1:0]         num_ff, num_in;
   logic [DEN_W-1:0]         den_ff, den_in;
   logic [BRP_W-1:0]         brp_ff, brp_in;
   logic [Q_W-1:0]           quanta_ff, quanta_in;
   logic [RES_W-1:0]         pend_cnf_ff, pend_cnf_in;
   logic [STATUS_W-1:0]      pend_status_ff, pend_status_in;
   logic                     rsp_tvalid_ff, rsp_tvalid_in;
   logic [RES_W-1:0]         rsp_tdata_ff, rsp_tdata_in;
   logic [STATUS_W-1:0]      rsp_tuser_ff, rsp_tuser_in;

   logic                     req_accept;
   logic                     div_start;
   logic                     out_load;
   logic                     quanta_fit;
   logic                     last_try;
   logic                     seg_bad;
   logic [RES_W-1:0]         seg_cnf;
   logic [RATE_W-1:0]        req_rate;

   div_status_type           div_status;
   logic [NUM_W-1:0]         div_quo;
   logic [DEN_W-1:0]         div_rem;

   cbtc_div #(
      .DIVIDEND_W (NUM_W),
      .DIVISOR_W  (DEN_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (num_ff),
      .divisor   (den_ff),
      .status    (div_status),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign req_rate   = req_tdata[RATE_W-1:0];
   assign req_accept = req_tvalid && req_tready;

   // A try succeeds when the division is exact and the quantum count is in range.
   assign quanta_fit = (div_rem == '0) && (div_quo != '0) &&
                       (div_quo <= NUM_W'(MAX_QUANTA));
   assign last_try   = (brp_ff == BRP_W'(PRESCALER_TRIES - 1));

   // Segment split of the found quantum count. The sample point is floor(0.8*q),
   // done as a constant reciprocal multiply; phase 2 is what remains after it.
   always_comb begin
      logic [X_W-1:0]  x4;
      logic [P_W-1:0]  scaled;
      logic [Q_W-1:0]  spt;
      logic [Q_W-1:0]  prop_u;
      logic [SW-1:0]   prop_s;
      logic [SW-1:0]   ps1_s;
      logic [SW-1:0]   ps2_s;
      logic [SW-1:0]   sum_s;
      x4     = {quanta_ff, 2'b00};
      scaled = P_W'(x4) * P_W'(SPT_RECIP);
      spt    = Q_W'(scaled >> SPT_SHIFT);
      prop_u = (spt != '0) ? ((spt - Q_W'(1)) >> 1) : '0;
      prop_s = SW'(prop_u);
      ps1_s  = SW'(spt) - prop_s - SW'(1);
      ps2_s  = SW'(quanta_ff) - SW'(spt);
      sum_s  = prop_s + ps1_s;
      seg_bad = ($signed(prop_s) < $signed(SW'(SEG_MIN)))    ||
                ($signed(prop_s) > $signed(SW'(SEG_MAX)))    ||
                ($signed(ps1_s)  < $signed(SW'(SEG_MIN)))    ||
                ($signed(ps1_s)  > $signed(SW'(SEG_MAX)))    ||
                ($signed(ps2_s)  < $signed(SW'(PHASE2_MIN))) ||
                ($signed(ps2_s)  > $signed(SW'(SEG_MAX)))    ||
                ($signed(sum_s)  < $signed(ps2_s));
      seg_cnf = {
         {5'b00000, ps2_s[2:0] - 3'd1},
         CNF2_LENGTH_MODE | {2'b00, ps1_s[2:0] - 3'd1, prop_s[2:0] - 3'd1},
         {{(CNF_W-BRP_W){1'b0}}, brp_ff}
      };
   end

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if ((req_rate == SPECIAL_RATE) || (req_rate == '0)) begin
                  state_in = ST_RESULT;
               end else begin
                  state_in = ST_DIV_START;
               end
            end
         end
         ST_DIV_START: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_status.done) begin
               if (quanta_fit) begin
                  state_in = ST_SEGMENT;
               end else if (last_try) begin
                  state_in = ST_RESULT;
               end else begin
                  state_in = ST_DIV_START;
               end
            end
         end
         ST_SEGMENT: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output decode of the sequencer.
   always_comb begin
      req_tready = 1'b0;
      div_start  = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE:      req_tready = 1'b1;
         ST_DIV_START: div_start  = 1'b1;
         ST_DIV_WAIT:  ;
         ST_SEGMENT:   ;
         ST_RESULT:    out_load   = !rsp_tvalid_ff || rsp_tready;
         default:      ;
      endcase
   end

   // Datapath registers of the search and the response skid register.
   always_comb begin
      osc_in         = osc_ff;
      rate_in        = rate_ff;
      num_in         = num_ff;
      den_in         = den_ff;
      brp_in         = brp_ff;
      quanta_in      = quanta_ff;
      pend_cnf_in    = pend_cnf_ff;
      pend_status_in = pend_status_ff;
      rsp_tvalid_in  = rsp_tvalid_ff;
      rsp_tdata_in   = rsp_tdata_ff;
      rsp_tuser_in   = rsp_tuser_ff;

      if (csr_valid) begin
         osc_in = csr_wdata[OSC_W-1:0];
      end

      if (req_accept) begin
         rate_in = req_rate;
         num_in  = NUM_W'(osc_ff * NUM_SCALE);
         den_in  = DEN_W'(req_rate);
         brp_in  = '0;
         if (req_rate == SPECIAL_RATE) begin
            pend_cnf_in    = {SPECIAL_CNF3, SPECIAL_CNF2, SPECIAL_CNF1};
            pend_status_in = STATUS_OK;
         end else begin
            // A zero rate can never give an exact count and is reported at once.
            pend_cnf_in    = '0;
            pend_status_in = STATUS_NO_PRESCALER;
         end
      end

      if ((state_ff == ST_DIV_WAIT) && div_status.done) begin
         if (quanta_fit) begin
            quanta_in = Q_W'(div_quo);
         end else if (last_try) begin
            pend_cnf_in    = '0;
            pend_status_in = STATUS_NO_PRESCALER;
         end else begin
            brp_in = brp_ff + BRP_W'(1);
            den_in = den_ff + DEN_W'(rate_ff);
         end
      end

      if (state_ff == ST_SEGMENT) begin
         if (seg_bad) begin
            pend_cnf_in    = '0;
            pend_status_in = STATUS_BAD_SEGMENTS;
         end else begin
            pend_cnf_in    = seg_cnf;
            pend_status_in = STATUS_OK;
         end
      end

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
      if (out_load) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = pend_cnf_ff;
         rsp_tuser_in  = pend_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         osc_ff        <= OSC_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         osc_ff        <= osc_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rate_ff        <= rate_in;
      num_ff         <= num_in;
      den_ff         <= den_in;
      brp_ff         <= brp_in;
      quanta_ff      <= quanta_in;
      pend_cnf_ff    <= pend_cnf_in;
      pend_status_ff <= pend_status_in;
      rsp_tdata_ff   <= rsp_tdata_in;
      rsp_tuser_ff   <= rsp_tuser_in;
   end

   // The configuration register takes a write in any cycle.
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // A new transaction is never taken while the divider is still working.
   `CBTC_ASSERT_IMPL(a_accept_div_idle, clock, reset, req_accept, !div_status.busy)
   // The divider only reports completion while the sequencer waits for it.
   `CBTC_ASSERT_IMPL(a_done_in_wait, clock, reset, div_status.done, state_ff == ST_DIV_WAIT)
   // A failed transaction carries all-zero configuration bytes.
   `CBTC_ASSERT_IMPL(a_fail_zero, clock, reset, rsp_tvalid && (rsp_tuser != STATUS_OK),
                     rsp_tdata == '0)
   // A successful transaction always sets the length mode bit of cnf2.
   `CBTC_ASSERT_IMPL(a_ok_length_mode, clock, reset, rsp_tvalid && (rsp_tuser == STATUS_OK),
                     rsp_tdata[15])
   // Loading the response register always presents a response in the next cycle.
   `CBTC_ASSERT_NEXT(a_load_shows, clock, reset, out_load, rsp_tvalid)

endmodule

>>> tb/can_bit_timing_checker.sv
`timescale 1ns / 1ps
// Checker that predicts every bit-timing response of the calculator and compares it.
module can_bit_timing_checker
   import cbtc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [5:0]  csr_wdata,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   output int          fail_count,
   output int          pending_count
);

   typedef struct packed {
      logic [RATE_W-1:0]   rate;
      logic [OSC_W-1:0]    osc;
      logic [CNF_W-1:0]    cnf1;
      logic [CNF_W-1:0]    cnf2;
      logic [CNF_W-1:0]    cnf3;
      logic [STATUS_W-1:0] status;
   } timing_word_type;

   timing_word_type  expected_timing_q[$];
   timing_word_type  want;
   logic [OSC_W-1:0] osc_copy;

   function automatic timing_word_type compute_bit_timing(input logic [RATE_W-1:0] rate,
                                                          input logic [OSC_W-1:0]  osc);
      timing_word_type w;
      int              num;
      int              den;
      int              quanta;
      int              brp;
      bit              found;
      int              spt;
      int              prop;
      int              ps1;
      int              ps2;
      w        = '0;
      w.rate   = rate;
      w.osc    = osc;
      w.status = STATUS_OK;
      if (rate == SPECIAL_RATE) begin
         w.cnf1 = SPECIAL_CNF1;
         w.cnf2 = SPECIAL_CNF2;
         w.cnf3 = SPECIAL_CNF3;
         return w;
      end
      num    = NUM_SCALE * int'(osc);
      found  = 1'b0;
      quanta = 0;
      brp    = 0;
      if (rate != '0) begin
         for (int p = 0; p < DEF_PRESCALER_TRIES && !found; p++) begin
            den = (p + 1) * int'(rate);
            if (num % den == 0 && num / den >= 1 && num / den <= DEF_MAX_QUANTA) begin
               quanta = num / den;
               brp    = p;
               found  = 1'b1;
            end
         end
      end
      if (!found) begin
         w.status = STATUS_NO_PRESCALER;
         return w;
      end
      // Sample point at 80 percent of the bit, rounded down.
      spt  = (4 * quanta) / 5;
      prop = (spt >= 1) ? (spt - 1) / 2 : 0;
      ps1  = spt - prop - 1;
      ps2  = quanta - ps1 - prop - 1;
      if (prop < SEG_MIN || prop > SEG_MAX || ps1 < SEG_MIN || ps1 > SEG_MAX ||
          ps2 < PHASE2_MIN || ps2 > SEG_MAX || prop + ps1 < ps2) begin
         w.status = STATUS_BAD_SEGMENTS;
         return w;
      end
      w.cnf1 = CNF_W'(brp & 'h3F);
      w.cnf2 = CNF2_LENGTH_MODE | CNF_W'((ps1 - 1) << 3) | CNF_W'(prop - 1);
      w.cnf3 = CNF_W'(ps2 - 1);
      return w;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         osc_copy = OSC_RESET;
         expected_timing_q.delete();
         fail_count    = 0;
         pending_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_timing_q.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected response: cnf1=%h cnf2=%h cnf3=%h status=%0d",
                           rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16], rsp_tuser);
               fail_count++;
            end else begin
               want = expected_timing_q.pop_front();
               if (rsp_tdata[7:0] !== want.cnf1 || rsp_tdata[15:8] !== want.cnf2 ||
                   rsp_tdata[23:16] !== want.cnf3 || rsp_tuser !== want.status) begin
                  if (fail_count < 10)
                     $display({"mismatch rate=%0d osc=%0d: expected %h %h %h st=%0d, ",
                               "got %h %h %h st=%0d"},
                              want.rate, want.osc, want.cnf1, want.cnf2, want.cnf3,
                              want.status, rsp_tdata[7:0], rsp_tdata[15:8],
                              rsp_tdata[23:16], rsp_tuser);
                  fail_count++;
               end
            end
         end
         // A request taken at the same edge as a write still sees the old oscillator.
         if (req_tvalid && req_tready)
            expected_timing_q.push_back(compute_bit_timing(req_tdata[RATE_W-1:0], osc_copy));
         if (csr_valid && csr_ready)
            osc_copy = csr_wdata;
         pending_count = expected_timing_q.size();
      end
   end

endmodule

>>> tb/can_bit_timing_calculator_tb.sv
`timescale 1ns / 1ps
// Top of the testbench for the CAN bit-timing calculator: stimulus, flow control and verdict.
module can_bit_timing_calculator_tb;
   import cbtc_pkg::*;

   // Every transaction is computed one at a time, with random gaps on both sides;
   // CYCLE_LIMIT bounds the whole run.
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int PHASE_COUNT     = 12;
   localparam int ITEMS_PER_PHASE = 146;
   localparam int HOLD_CYCLES     = 500;
   localparam int DRAIN_CYCLES    = 200;
   localparam int DIRECTED_COUNT  = 14;

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [5:0]  csr_wdata;      // osc_mhz[5:0]
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;      // bit_rate_kbps[9:0], zero padding [15:10]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;      // cnf1[7:0], cnf2[15:8], cnf3[23:16]
   logic [1:0]  rsp_tuser;      // status[1:0]

   int fail_count;
   int pending_count;
   int cycle_count;

   // Shared flow-control knobs. The receiver clears hold_request once it has
   // started its long hold-off; idle_enable turns random gaps on both sides on.
   bit idle_enable;
   bit hold_request;

   logic [OSC_W-1:0]  phase_osc     [0:PHASE_COUNT-1];
   logic [RATE_W-1:0] directed_rate [0:DIRECTED_COUNT-1];

   can_bit_timing_calculator dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   can_bit_timing_checker timing_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_wdata     (csr_wdata),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // A hung handshake or a lost response ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Picks a bit rate for the given oscillator. Most picks are rates that divide
   // the oscillator into a whole number of quanta, so the segment logic is reached;
   // the rest are arbitrary rates that mostly find no prescaler.
   function automatic logic [RATE_W-1:0] pick_rate(input logic [OSC_W-1:0] osc);
      logic [RATE_W-1:0] rate;
      int                num;
      int                den;
      bit                hit;
      rate = RATE_W'($urandom_range(1023, 0));
      num  = NUM_SCALE * int'(osc);
      hit  = 1'b0;
      if ($urandom_range(99, 0) < 2) begin
         rate = SPECIAL_RATE;
      end else if ($urandom_range(99, 0) < 75 && osc != '0) begin
         for (int t = 0; t < 20 && !hit; t++) begin
            den = ($urandom_range(DEF_PRESCALER_TRIES - 1, 0) + 1) *
                  $urandom_range(DEF_MAX_QUANTA, 1);
            if (num % den == 0 && num / den >= 1 && num / den <= 1023) begin
               rate = RATE_W'(num / den);
               hit  = 1'b1;
            end
         end
      end
      return rate;
   endfunction

   // Offers one request and waits until it is accepted. Valid stays high into the
   // next request unless a random gap is taken right after the acceptance.
   task automatic send_rate(input logic [RATE_W-1:0] rate);
      req_tvalid <= 1'b1;
      req_tdata  <= {{(16 - RATE_W){1'b0}}, rate};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (idle_enable && $urandom_range(3, 0) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(7, 1)) @(posedge clock);
      end
   endtask

   // Lowers the request valid and waits until every expected response has come.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Writes osc_mhz; only called while the block has nothing in flight.
   task automatic write_osc(input logic [OSC_W-1:0] osc);
      csr_valid <= 1'b1;
      csr_wdata <= osc;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Response side: random stall bursts, and one long hold-off on request so that
   // the block fills up and stalls its request channel.
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else if (idle_enable && $urandom_range(4, 0) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(7, 1) - 1) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      // Oscillator settings per random phase, the extremes of the field among them.
      phase_osc[0]  = 6'd40;
      phase_osc[1]  = 6'd1;
      phase_osc[2]  = 6'd63;
      phase_osc[3]  = 6'd16;
      phase_osc[4]  = 6'd25;
      phase_osc[5]  = 6'd8;
      phase_osc[6]  = 6'd0;
      phase_osc[7]  = 6'd33;
      phase_osc[8]  = 6'd20;
      phase_osc[9]  = 6'd10;
      phase_osc[10] = 6'd5;
      phase_osc[11] = 6'd32;

      // Rates checked against the oscillator value left by reset: clean fits at
      // several quantum counts, too many quanta for the segment rules, the fixed
      // answer for 83, a zero rate, and the field's extremes.
      directed_rate[0]  = 10'd1000;
      directed_rate[1]  = 10'd800;
      directed_rate[2]  = 10'd500;
      directed_rate[3]  = 10'd400;
      directed_rate[4]  = 10'd320;
      directed_rate[5]  = SPECIAL_RATE;
      directed_rate[6]  = 10'd0;
      directed_rate[7]  = 10'd1;
      directed_rate[8]  = 10'd1023;
      directed_rate[9]  = 10'd512;
      directed_rate[10] = 10'd250;
      directed_rate[11] = 10'd100;
      directed_rate[12] = 10'd640;
      directed_rate[13] = 10'd1010;

      idle_enable  = 1'b1;
      hold_request = 1'b0;
      cycle_count  = 0;
      reset      <= 1'b1;
      csr_valid  <= 1'b0;
      csr_wdata  <= '0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_COUNT; i++)
         send_rate(directed_rate[i]);
      wait_drained();

      // A zero oscillator never fits, but the fixed answer for 83 still holds.
      write_osc(6'd0);
      send_rate(SPECIAL_RATE);
      send_rate(10'd500);
      send_rate(10'd0);
      wait_drained();

      write_osc(6'd40);
      send_rate(10'd1000);
      send_rate(SPECIAL_RATE);
      send_rate(10'd1023);
      wait_drained();

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         write_osc(phase_osc[ph]);
         // The last phase runs with no gaps on either side.
         if (ph == PHASE_COUNT - 1)
            idle_enable = 1'b0;
         // One phase starts with the response side held off for a long stretch
         // while requests keep being offered.
         if (ph == 2)
            hold_request = 1'b1;
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            send_rate(pick_rate(phase_osc[ph]));
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
